// File: hw/rtl/scpr_pkg.sv
package scpr_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;

    localparam int PAGE_NUM_W  = 16;
    localparam int FRAME_IDX_W = 4;
    localparam int CFG_FIU_W   = 5;
    localparam int COUNT_W     = 32;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Register word index as decoded from paddr.
    localparam logic REG_FRAMES_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP
    } t_state;

    typedef struct packed {
        logic load_page;
        logic hit_update;
        logic start_sweep;
        logic clear_advance;
        logic place;
    } t_ctrl_cmd;

    typedef struct packed {
        logic found;
        logic ref_at_hand;
    } t_dp_status;

    // Width of the frames_in_use register: the written field, or wide enough
    // to hold the reset value of the built frame count.
    function automatic int fiu_width(input int max_frames);
        int w;
        w = $clog2(max_frames + 1);
        return (w > CFG_FIU_W) ? w : CFG_FIU_W;
    endfunction

endpackage

// File: hw/rtl/scpr_regs.sv
module scpr_regs #(
    parameter int MAX_FRAMES = scpr_pkg::MAX_FRAMES_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         psel,
    input  logic                                         penable,
    input  logic                                         pwrite,
    input  logic [scpr_pkg::APB_ADDR_W-1:0]              paddr,
    input  logic [scpr_pkg::APB_DATA_W-1:0]              pwdata,
    output logic [scpr_pkg::APB_DATA_W-1:0]              prdata,
    output logic                                         pready,
    output logic [scpr_pkg::fiu_width(MAX_FRAMES)-1:0]   o_frames_in_use
);

    localparam int FIU_W = scpr_pkg::fiu_width(MAX_FRAMES);

    logic [FIU_W-1:0] r_frames_in_use;
    logic             w_sel_fiu;

    assign w_sel_fiu = (paddr[2] == scpr_pkg::REG_FRAMES_IN_USE);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= FIU_W'(MAX_FRAMES);
        end else if (psel && penable && pwrite && pready && w_sel_fiu) begin
            r_frames_in_use <= FIU_W'(pwdata[scpr_pkg::CFG_FIU_W-1:0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_fiu) begin
            prdata = scpr_pkg::APB_DATA_W'(r_frames_in_use);
        end
    end

    assign o_frames_in_use = r_frames_in_use;

endmodule

// File: hw/rtl/scpr_ctrl.sv
module scpr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  scpr_pkg::t_dp_status i_status,
    output scpr_pkg::t_ctrl_cmd  o_cmd,
    output logic                 o_busy
);

    scpr_pkg::t_state r_state;
    scpr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scpr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scpr_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = scpr_pkg::ST_LOOKUP;
                end
            end
            scpr_pkg::ST_LOOKUP: begin
                n_state = i_status.found ? scpr_pkg::ST_IDLE : scpr_pkg::ST_SWEEP;
            end
            scpr_pkg::ST_SWEEP: begin
                if (!i_status.ref_at_hand) begin
                    n_state = scpr_pkg::ST_IDLE;
                end
            end
            default: n_state = scpr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            scpr_pkg::ST_IDLE: begin
                o_busy          = 1'b0;
                o_cmd.load_page = i_start;
            end
            scpr_pkg::ST_LOOKUP: begin
                o_cmd.hit_update  = i_status.found;
                o_cmd.start_sweep = !i_status.found;
            end
            scpr_pkg::ST_SWEEP: begin
                // A set bit buys the frame another pass; a clear one takes the page.
                o_cmd.clear_advance = i_status.ref_at_hand;
                o_cmd.place         = !i_status.ref_at_hand;
            end
            default: o_busy = 1'b1;
        endcase
    end

endmodule

// File: hw/rtl/scpr_dpath.sv
module scpr_dpath #(
    parameter int MAX_FRAMES = scpr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = scpr_pkg::PAGE_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [scpr_pkg::fiu_width(MAX_FRAMES)-1:0] i_frames_in_use,
    input  logic [scpr_pkg::PAGE_NUM_W-1:0]            i_page_number,
    input  scpr_pkg::t_ctrl_cmd                        i_cmd,
    output scpr_pkg::t_dp_status                       o_status,
    output logic                                       o_done,
    output logic                                       o_hit,
    output logic [scpr_pkg::FRAME_IDX_W-1:0]           o_frame_index,
    output logic                                       o_evicted_valid,
    output logic [scpr_pkg::PAGE_NUM_W-1:0]            o_evicted_page,
    output logic [scpr_pkg::COUNT_W-1:0]               o_miss_count,
    output logic [scpr_pkg::COUNT_W-1:0]               o_hit_count
);

    localparam int FIU_W = scpr_pkg::fiu_width(MAX_FRAMES);
    localparam int CW    = $clog2(MAX_FRAMES + 1);
    localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int SW    = (PAGE_BITS < scpr_pkg::PAGE_NUM_W) ? PAGE_BITS
                                                               : scpr_pkg::PAGE_NUM_W;

    logic [SW-1:0]               r_resident [MAX_FRAMES];
    logic [MAX_FRAMES-1:0]       r_valid;
    logic [MAX_FRAMES-1:0]       r_ref;
    logic [FW-1:0]               r_hand;
    logic [SW-1:0]               r_page;
    logic [scpr_pkg::COUNT_W-1:0] r_misses;
    logic [scpr_pkg::COUNT_W-1:0] r_hits;

    logic                               r_done;
    logic                               r_hit;
    logic [scpr_pkg::FRAME_IDX_W-1:0]   r_frame;
    logic                               r_ev_valid;
    logic [scpr_pkg::PAGE_NUM_W-1:0]    r_ev_page;

    logic [CW-1:0]         w_count;
    logic [MAX_FRAMES-1:0] w_match;
    logic [FW-1:0]         w_hit_idx;
    logic [FW-1:0]         w_hand_next;
    logic [FW-1:0]         w_hand_start;

    // Zero frames counts as one; anything above the built count saturates.
    always_comb begin
        priority if (i_frames_in_use == '0) begin
            w_count = CW'(1);
        end else if (FIU_W'(MAX_FRAMES) < i_frames_in_use) begin
            w_count = CW'(MAX_FRAMES);
        end else begin
            w_count = CW'(i_frames_in_use);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            w_match[i] = r_valid[i] && (r_resident[i] == r_page) && (i < int'(w_count));
        end
    end

    // Several frames can match only after the frame count changed; the lowest wins.
    always_comb begin
        w_hit_idx = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit_idx = FW'(i);
            end
        end
    end

    assign w_hand_next  = ((CW'(r_hand) + CW'(1)) >= w_count) ? '0 : FW'(CW'(r_hand) + CW'(1));
    assign w_hand_start = (CW'(r_hand) < w_count) ? r_hand : '0;

    assign o_status.found       = |w_match;
    assign o_status.ref_at_hand = r_ref[r_hand];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_ref    <= '0;
            r_hand   <= '0;
            r_misses <= '0;
            r_hits   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.hit_update || i_cmd.place;
            if (i_cmd.hit_update) begin
                r_ref  <= r_ref | w_match;
                r_hits <= (r_hits == '1) ? r_hits : r_hits + 1'b1;
            end
            if (i_cmd.start_sweep) begin
                r_hand <= w_hand_start;
            end
            if (i_cmd.clear_advance) begin
                r_ref[r_hand] <= 1'b0;
                r_hand        <= w_hand_next;
            end
            if (i_cmd.place) begin
                r_valid[r_hand] <= 1'b1;
                r_ref[r_hand]   <= 1'b0;
                r_hand          <= w_hand_next;
                r_misses        <= (r_misses == '1) ? r_misses : r_misses + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_page) begin
            r_page <= i_page_number[SW-1:0];
        end
        if (i_cmd.place) begin
            r_resident[r_hand] <= r_page;
        end
        if (i_cmd.hit_update) begin
            r_hit      <= 1'b1;
            r_frame    <= scpr_pkg::FRAME_IDX_W'(w_hit_idx);
            r_ev_valid <= 1'b0;
            r_ev_page  <= '0;
        end
        if (i_cmd.place) begin
            r_hit      <= 1'b0;
            r_frame    <= scpr_pkg::FRAME_IDX_W'(r_hand);
            r_ev_valid <= r_valid[r_hand];
            r_ev_page  <= r_valid[r_hand] ? scpr_pkg::PAGE_NUM_W'(r_resident[r_hand]) : '0;
        end
    end

    assign o_done          = r_done;
    assign o_hit           = r_hit;
    assign o_frame_index   = r_frame;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_miss_count    = r_misses;
    assign o_hit_count     = r_hits;

endmodule

// File: hw/rtl/second_chance_page_replacer_top.sv
// Second-chance (clock) page replacement unit.
// Issue one page reference by raising i_start with i_page_number while o_busy
// is low; the item is taken at that clock edge and o_busy rises.
// In the LOOKUP state that follows, the parallel tag compare decides hit or
// miss. A hit sets the reference bit of the matching frame and the result
// follows at once on the o_done strobe. A miss walks the clock hand one
// frame per cycle, clearing set reference bits, until a frame with a clear
// bit takes the page.
// o_busy falls in the cycle of the o_done strobe, so a new item can be issued
// there. Results appear for exactly one cycle on o_done and cannot be held off.
// The APB port holds frames_in_use at byte address 0; write it only while idle.
// Reset (synchronous, active low) empties every frame, clears all reference
// bits, the hand and both counters, and sets frames_in_use to the built count.
module second_chance_page_replacer_top #(
    parameter int MAX_FRAMES = scpr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = scpr_pkg::PAGE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [scpr_pkg::PAGE_NUM_W-1:0]    i_page_number,
    output logic                               o_done,
    output logic                               o_hit,
    output logic [scpr_pkg::FRAME_IDX_W-1:0]   o_frame_index,
    output logic                               o_evicted_valid,
    output logic [scpr_pkg::PAGE_NUM_W-1:0]    o_evicted_page,
    output logic [scpr_pkg::COUNT_W-1:0]       o_miss_count,
    output logic [scpr_pkg::COUNT_W-1:0]       o_hit_count,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [scpr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [scpr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [scpr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int FIU_W = scpr_pkg::fiu_width(MAX_FRAMES);

    logic [FIU_W-1:0]     w_frames_in_use;
    scpr_pkg::t_ctrl_cmd  w_cmd;
    scpr_pkg::t_dp_status w_status;

    scpr_regs #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_frames_in_use(w_frames_in_use)
    );

    scpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_status(w_status),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    scpr_dpath #(
        .MAX_FRAMES(MAX_FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frames_in_use(w_frames_in_use),
        .i_page_number  (i_page_number),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_frame_index  (o_frame_index),
        .o_evicted_valid(o_evicted_valid),
        .o_evicted_page (o_evicted_page),
        .o_miss_count   (o_miss_count),
        .o_hit_count    (o_hit_count)
    );

endmodule
